### src/mlft_pkg.sv
package mlft_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int NUM_PORTS_DEF   = 8;
	localparam logic [31:0] AGE_RESET_MS = 32'd15000;

	localparam int MAC_W   = 48;
	localparam int PORT_W  = 3;
	localparam int TIME_W  = 32;
	localparam int MASK_W  = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [1:0] {
		ACT_FORWARD = 2'd0,
		ACT_FLOOD   = 2'd1,
		ACT_DROP    = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CONNECTED_PORTS = 8'd0,
		REG_AGE_LIMIT_MS    = 8'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [MAC_W-1:0]  src_mac;
		logic [MAC_W-1:0]  dst_mac;
		logic [PORT_W-1:0] ingress_port;
		logic [TIME_W-1:0] now_ms;
	} frame_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [PORT_W-1:0] egress_port;
		logic [MASK_W-1:0] egress_mask;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_t;

	typedef struct packed {
		logic [MAC_W-1:0]  address;
		logic [PORT_W-1:0] port;
		logic [TIME_W-1:0] stamp;
	} entry_t;

endpackage

### src/mlft_stream_if.sv
interface mlft_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### src/mlft_ram.sv
module mlft_ram #(
	parameter int DEPTH = mlft_pkg::TABLE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  mlft_pkg::entry_t         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output mlft_pkg::entry_t         rdata
);
	mlft_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### src/mac_learning_forward_table.sv
// learning address table for an ethernet switch. each frame beat on frame carries source and
// destination address, ingress port and a millisecond time. the block learns the source (refresh
// of port and stamp, or the lowest free slot, or nothing when the table is full), then looks up
// the destination: miss or full table floods to the connected ports but the ingress one, an entry
// older than age_limit_ms is removed and the frame floods, a destination on the ingress port is
// dropped, anything else is forwarded. one result beat per frame. one entry is read per cycle
// from the read port of the entry memory, then the finish state writes back the learned entry
// and issues the verdict once the result register is empty or its beat is taken. valid bits sit in
// flops, so no clearing pass follows reset. the result register lets the next frame start while
// a verdict waits; configuration beats are taken at any time and must only arrive while idle.
module mac_learning_forward_table #(
	parameter int TABLE_DEPTH = mlft_pkg::TABLE_DEPTH_DEF,
	parameter int NUM_PORTS   = mlft_pkg::NUM_PORTS_DEF
) (
	input logic clk,
	input logic arst_n,
	mlft_stream_if.sink   frame,
	mlft_stream_if.source result,
	mlft_stream_if.sink   cfg
);
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [mlft_pkg::MASK_W-1:0] PORT_MASK = (NUM_PORTS >= mlft_pkg::MASK_W) ?
		{mlft_pkg::MASK_W{1'b1}} : mlft_pkg::MASK_W'((1 << NUM_PORTS) - 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	mlft_pkg::state_t state_q, state_d;

	// frame under work
	mlft_pkg::frame_t frame_q;

	// scan control
	logic [IDX_W-1:0] cnt_q;
	logic             issue_done_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] idx_s1;

	// table state kept in flops
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [CNT_W-1:0]       count_q;

	// scan findings
	logic                       src_hit_q, dst_hit_q, free_hit_q;
	logic [IDX_W-1:0]           src_idx_q, dst_idx_q, free_idx_q;
	logic [mlft_pkg::PORT_W-1:0] dst_port_q;
	logic [mlft_pkg::TIME_W-1:0] dst_stamp_q;

	// configuration
	logic [mlft_pkg::MASK_W-1:0] connected_q;
	logic [mlft_pkg::TIME_W-1:0] age_q;

	// result register
	mlft_pkg::result_t out_q;
	logic              out_vld_q;

	mlft_pkg::entry_t rd_data;
	mlft_pkg::entry_t wr_data;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;

	// finish-cycle decision
	logic                        fire;
	logic                        learn, new_slot, same_addr, d_hit, full, expired, drop_entry;
	logic [IDX_W-1:0]            d_idx;
	logic [mlft_pkg::PORT_W-1:0] d_port;
	logic [mlft_pkg::TIME_W-1:0] d_stamp, age;
	logic [CNT_W-1:0]            count_l;
	logic [mlft_pkg::MASK_W-1:0] flood;
	mlft_pkg::result_t           res_d;
	logic                        entry_v;
	logic [TABLE_DEPTH-1:0]      valid_d;

	mlft_ram #(.DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata (wr_data),
		.raddr (cnt_q),
		.rdata (rd_data)
	);

	assign frame.ready  = (state_q == mlft_pkg::ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign result.valid = out_vld_q;
	assign result.payload = out_q;

	assign entry_v = valid_q[idx_s1];

	// learn and verdict, all from registered scan findings
	always_comb begin
		fire      = (state_q == mlft_pkg::ST_FINISH) && (!out_vld_q || result.ready);
		learn     = src_hit_q || free_hit_q;
		new_slot  = !src_hit_q && free_hit_q;
		wr_idx    = src_hit_q ? src_idx_q : free_idx_q;
		wr_en     = fire && learn;
		wr_data.address = frame_q.src_mac;
		wr_data.port    = frame_q.ingress_port;
		wr_data.stamp   = frame_q.now_ms;
		// destination equal to the freshly learned source sees the new entry
		same_addr = learn && (frame_q.dst_mac == frame_q.src_mac);
		d_hit     = same_addr || dst_hit_q;
		d_idx     = same_addr ? wr_idx : dst_idx_q;
		d_port    = same_addr ? frame_q.ingress_port : dst_port_q;
		d_stamp   = same_addr ? frame_q.now_ms : dst_stamp_q;
		count_l   = count_q + CNT_W'(new_slot);
		full      = (count_l == CNT_W'(TABLE_DEPTH));
		age       = frame_q.now_ms - d_stamp;
		expired   = age > age_q;
		flood     = connected_q & PORT_MASK &
			~(mlft_pkg::MASK_W'(1) << frame_q.ingress_port);
		drop_entry = 1'b0;
		res_d.egress_port = '0;
		if (!d_hit || full) begin
			res_d.action      = mlft_pkg::ACT_FLOOD;
			res_d.egress_mask = flood;
		end else if (expired) begin
			drop_entry        = 1'b1;
			res_d.action      = mlft_pkg::ACT_FLOOD;
			res_d.egress_mask = flood;
		end else if (d_port == frame_q.ingress_port) begin
			res_d.action      = mlft_pkg::ACT_DROP;
			res_d.egress_mask = '0;
		end else begin
			res_d.action      = mlft_pkg::ACT_FORWARD;
			res_d.egress_port = d_port;
			res_d.egress_mask = mlft_pkg::MASK_W'(1) << d_port;
		end
		// valid bits after learning the source and removing a stale destination
		valid_d = valid_q;
		if (new_slot) begin
			valid_d[wr_idx] = 1'b1;
		end
		if (drop_entry) begin
			valid_d[d_idx] = 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mlft_pkg::ST_IDLE: begin
				if (frame.valid) begin
					state_d = mlft_pkg::ST_SCAN;
				end
			end
			mlft_pkg::ST_SCAN: begin
				if (rd_vld_s1 && idx_s1 == LAST_IDX) begin
					state_d = mlft_pkg::ST_FINISH;
				end
			end
			mlft_pkg::ST_FINISH: begin
				if (fire) begin
					state_d = mlft_pkg::ST_IDLE;
				end
			end
			default: state_d = mlft_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlft_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			valid_q      <= '0;
			count_q      <= '0;
			src_hit_q    <= 1'b0;
			dst_hit_q    <= 1'b0;
			free_hit_q   <= 1'b0;
			connected_q  <= '0;
			age_q        <= mlft_pkg::AGE_RESET_MS;
			out_vld_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == mlft_pkg::ST_SCAN) && !issue_done_q;
			if (frame.valid && frame.ready) begin
				cnt_q        <= '0;
				issue_done_q <= 1'b0;
				src_hit_q    <= 1'b0;
				dst_hit_q    <= 1'b0;
				free_hit_q   <= 1'b0;
			end else if (state_q == mlft_pkg::ST_SCAN && !issue_done_q) begin
				if (cnt_q == LAST_IDX) begin
					issue_done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + IDX_W'(1);
				end
			end
			if (rd_vld_s1) begin
				if (entry_v && rd_data.address == frame_q.src_mac) begin
					src_hit_q <= 1'b1;
				end
				if (entry_v && rd_data.address == frame_q.dst_mac) begin
					dst_hit_q <= 1'b1;
				end
				if (!entry_v && !free_hit_q) begin
					free_hit_q <= 1'b1;
				end
			end
			if (fire) begin
				valid_q <= valid_d;
				count_q <= count_l - CNT_W'(drop_entry);
			end
			if (cfg.valid) begin
				unique case (cfg.payload.index)
					mlft_pkg::REG_CONNECTED_PORTS:
						connected_q <= cfg.payload.data[mlft_pkg::MASK_W-1:0];
					mlft_pkg::REG_AGE_LIMIT_MS:
						age_q <= cfg.payload.data[mlft_pkg::TIME_W-1:0];
					default: ;
				endcase
			end
			if (fire) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (frame.valid && frame.ready) begin
			frame_q <= frame.payload;
		end
		if (rd_vld_s1) begin
			if (entry_v && rd_data.address == frame_q.src_mac) begin
				src_idx_q <= idx_s1;
			end
			if (entry_v && rd_data.address == frame_q.dst_mac) begin
				dst_idx_q   <= idx_s1;
				dst_port_q  <= rd_data.port;
				dst_stamp_q <= rd_data.stamp;
			end
			if (!entry_v && !free_hit_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (fire) begin
			out_q <= res_d;
		end
	end

	// fill count never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	// fill count tracks the valid bits
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mlft_pkg::ST_IDLE |-> count_q == CNT_W'($countones(valid_q)))
		else $error("entry count out of step with valid bits");

	// a forward verdict names exactly one port
	a_forward_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_d.action == mlft_pkg::ACT_FORWARD |-> $onehot(res_d.egress_mask))
		else $error("forward without a single egress bit");

	// a verdict is only issued after a full scan
	a_finish_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == mlft_pkg::ST_FINISH) |-> issue_done_q)
		else $error("verdict before scan completed");
endmodule

### verif/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = mlft_pkg::TABLE_DEPTH_DEF;
	localparam int PORTS = mlft_pkg::NUM_PORTS_DEF;
	localparam longint CYCLE_LIMIT = 3000000;

	logic clk;
	logic arst_n;

	mlft_stream_if #(.payload_t(mlft_pkg::frame_t))  frame_if ();
	mlft_stream_if #(.payload_t(mlft_pkg::result_t)) result_if ();
	mlft_stream_if #(.payload_t(mlft_pkg::cfg_t))    cfg_if ();

	mac_learning_forward_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_if.sink),
		.result (result_if.source),
		.cfg    (cfg_if.sink)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// shadow copy of the table and registers, advanced as each frame is accepted
	logic                        tbl_valid [DEPTH];
	logic [mlft_pkg::MAC_W-1:0]  tbl_addr  [DEPTH];
	logic [mlft_pkg::PORT_W-1:0] tbl_port  [DEPTH];
	logic [mlft_pkg::TIME_W-1:0] tbl_stamp [DEPTH];
	int                          tbl_count;
	logic [mlft_pkg::MASK_W-1:0] sh_connected;
	logic [31:0]                 sh_age_limit;

	mlft_pkg::frame_t  pending_frames [$];
	mlft_pkg::result_t expected_verdicts [$];
	mlft_pkg::cfg_t    pending_cfg [$];

	int  frame_idle_pct;
	int  result_stall_pct;
	int  fail_count;
	longint cycle_count;

	// recently seen addresses, reused so that lookups hit
	logic [mlft_pkg::MAC_W-1:0] addr_pool [$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
			cycle_count);
		fail_count++;
	endtask

	function automatic int lookup_slot(input logic [mlft_pkg::MAC_W-1:0] addr);
		for (int i = 0; i < DEPTH; i++)
			if (tbl_valid[i] && tbl_addr[i] == addr)
				return i;
		return -1;
	endfunction

	function automatic logic [mlft_pkg::MASK_W-1:0] flood_ports(
			input logic [mlft_pkg::PORT_W-1:0] ingress);
		logic [mlft_pkg::MASK_W-1:0] m;
		m = sh_connected;
		// ingress ports beyond the populated ones have no bit to clear
		if (int'(ingress) < PORTS)
			m[ingress] = 1'b0;
		return m;
	endfunction

	// learn source, then decide on destination
	function automatic mlft_pkg::result_t forward_verdict(input mlft_pkg::frame_t f);
		mlft_pkg::result_t r;
		int s;
		logic [31:0] age;
		s = lookup_slot(f.src_mac);
		if (s < 0) begin
			for (int i = 0; i < DEPTH; i++)
				if (!tbl_valid[i]) begin
					s = i;
					break;
				end
			if (s >= 0) begin
				tbl_valid[s] = 1'b1;
				tbl_addr[s] = f.src_mac;
				tbl_count++;
			end
		end
		if (s >= 0) begin
			tbl_port[s] = f.ingress_port;
			tbl_stamp[s] = f.now_ms;
		end
		r = '0;
		s = lookup_slot(f.dst_mac);
		if (s >= 0)
			age = f.now_ms - tbl_stamp[s];
		if (s < 0 || tbl_count >= DEPTH) begin
			r.action = mlft_pkg::ACT_FLOOD;
			r.egress_mask = flood_ports(f.ingress_port);
		end else if (age > sh_age_limit) begin
			// stale destination is dropped from the table
			tbl_valid[s] = 1'b0;
			tbl_count--;
			r.action = mlft_pkg::ACT_FLOOD;
			r.egress_mask = flood_ports(f.ingress_port);
		end else if (tbl_port[s] == f.ingress_port) begin
			r.action = mlft_pkg::ACT_DROP;
		end else begin
			r.action = mlft_pkg::ACT_FORWARD;
			r.egress_port = tbl_port[s];
			r.egress_mask = 8'd1 << tbl_port[s];
		end
		return r;
	endfunction

	// frame driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_if.valid <= 1'b0;
			frame_if.payload <= '0;
		end else if (!frame_if.valid || frame_if.ready) begin
			if (pending_frames.size() > 0 &&
					$urandom_range(99) >= frame_idle_pct) begin
				frame_if.valid <= 1'b1;
				frame_if.payload <= pending_frames.pop_front();
			end else begin
				frame_if.valid <= 1'b0;
			end
		end
	end

	// config driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_if.valid <= 1'b0;
			cfg_if.payload <= '0;
		end else if (!cfg_if.valid || cfg_if.ready) begin
			if (pending_cfg.size() > 0) begin
				cfg_if.valid <= 1'b1;
				cfg_if.payload <= pending_cfg.pop_front();
			end else begin
				cfg_if.valid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_if.ready <= 1'b0;
		else
			result_if.ready <= ($urandom_range(99) >= result_stall_pct);
	end

	// monitor: accepted beats on every channel
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if (cfg_if.valid && cfg_if.ready) begin
				if (cfg_if.payload.index == mlft_pkg::REG_CONNECTED_PORTS)
					sh_connected = cfg_if.payload.data[mlft_pkg::MASK_W-1:0];
				else if (cfg_if.payload.index == mlft_pkg::REG_AGE_LIMIT_MS)
					sh_age_limit = cfg_if.payload.data;
			end
			if (frame_if.valid && frame_if.ready)
				expected_verdicts.push_back(forward_verdict(frame_if.payload));
			if (result_if.valid && result_if.ready) begin
				if (expected_verdicts.size() == 0) begin
					report_mismatch("unexpected result", 32'(result_if.payload), 32'd0);
				end else begin
					mlft_pkg::result_t want;
					want = expected_verdicts.pop_front();
					if (result_if.payload.action !== want.action)
						report_mismatch("action", 32'(result_if.payload.action),
							32'(want.action));
					if (result_if.payload.egress_port !== want.egress_port)
						report_mismatch("egress_port", 32'(result_if.payload.egress_port),
							32'(want.egress_port));
					if (result_if.payload.egress_mask !== want.egress_mask)
						report_mismatch("egress_mask", 32'(result_if.payload.egress_mask),
							32'(want.egress_mask));
				end
			end
			if (cycle_count > CYCLE_LIMIT) begin
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	function automatic logic [mlft_pkg::MAC_W-1:0] rand_mac();
		return mlft_pkg::MAC_W'({$urandom(), $urandom()});
	endfunction

	// pool address, or a fresh one that joins the pool
	function automatic logic [mlft_pkg::MAC_W-1:0] pick_mac();
		logic [mlft_pkg::MAC_W-1:0] a;
		if (addr_pool.size() > 0 && $urandom_range(99) < 80)
			return addr_pool[$urandom_range(addr_pool.size() - 1)];
		a = rand_mac();
		addr_pool.push_back(a);
		if (addr_pool.size() > 90)
			void'(addr_pool.pop_front());
		return a;
	endfunction

	task automatic queue_frame(input logic [mlft_pkg::MAC_W-1:0] s,
			input logic [mlft_pkg::MAC_W-1:0] d,
			input logic [mlft_pkg::PORT_W-1:0] p, input logic [mlft_pkg::TIME_W-1:0] t);
		mlft_pkg::frame_t f;
		f.src_mac = s;
		f.dst_mac = d;
		f.ingress_port = p;
		f.now_ms = t;
		pending_frames.push_back(f);
	endtask

	// wait for drain; the block may still be chewing on nothing, so add slack
	task automatic drain();
		while (pending_frames.size() > 0 || frame_if.valid || expected_verdicts.size() > 0)
			@(posedge clk);
		repeat (2 * DEPTH + 20) @(posedge clk);
	endtask

	task automatic wait_cfg();
		while (pending_cfg.size() > 0 || cfg_if.valid)
			@(posedge clk);
	endtask

	task automatic write_reg(input mlft_pkg::cfg_reg_t idx, input logic [31:0] data);
		mlft_pkg::cfg_t c;
		c.index = idx;
		c.data = data;
		pending_cfg.push_back(c);
		wait_cfg();
	endtask

	task automatic random_phase(input int n, input int idle, input int stall,
			input logic [mlft_pkg::TIME_W-1:0] t0, input int tstep);
		logic [mlft_pkg::TIME_W-1:0] t;
		t = t0;
		frame_idle_pct = idle;
		result_stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			t = t + $urandom_range(tstep);
			if ($urandom_range(99) < 5)
				queue_frame(rand_mac(), rand_mac(), 3'($urandom_range(7)), $urandom());
			else
				queue_frame(pick_mac(), pick_mac(), 3'($urandom_range(7)), t);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		frame_idle_pct = 0;
		result_stall_pct = 0;
		fail_count = 0;
		cycle_count = 0;
		for (int i = 0; i < DEPTH; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_addr[i] = '0;
			tbl_port[i] = '0;
			tbl_stamp[i] = '0;
		end
		tbl_count = 0;
		sh_connected = '0;
		sh_age_limit = mlft_pkg::AGE_RESET_MS;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset config first, then edge addresses and times
		queue_frame('0, {mlft_pkg::MAC_W{1'b1}}, 3'd0, '0);
		queue_frame({mlft_pkg::MAC_W{1'b1}}, '0, 3'd7, 32'd1);
		queue_frame(48'h0000_0000_0001, 48'h0000_0000_0001, 3'd2, 32'd5);
		drain();
		write_reg(mlft_pkg::REG_CONNECTED_PORTS, 32'hFF);
		write_reg(mlft_pkg::REG_AGE_LIMIT_MS, 32'd100);
		// an ignored index
		begin
			mlft_pkg::cfg_t c;
			c.index = 8'hFF;
			c.data = 32'hDEAD_BEEF;
			pending_cfg.push_back(c);
			wait_cfg();
		end
		queue_frame(48'hAAAA_0000_0001, 48'hBBBB_0000_0001, 3'd1, 32'd1000);
		queue_frame(48'hBBBB_0000_0001, 48'hAAAA_0000_0001, 3'd4, 32'd1010);
		queue_frame(48'hAAAA_0000_0001, 48'hBBBB_0000_0001, 3'd1, 32'd1020);
		queue_frame(48'hCCCC_0000_0001, 48'hBBBB_0000_0001, 3'd4, 32'd1030);
		// age exactly at the limit, then beyond it
		queue_frame(48'hCCCC_0000_0002, 48'hAAAA_0000_0001, 3'd3, 32'd1120);
		queue_frame(48'hCCCC_0000_0003, 48'hBBBB_0000_0001, 3'd3, 32'd1111);
		queue_frame(48'hCCCC_0000_0003, 48'hBBBB_0000_0001, 3'd3, 32'd1112);
		// time wrapping past zero
		queue_frame(48'hDDDD_0000_0001, 48'hEEEE_0000_0001, 3'd5, 32'hFFFF_FFF0);
		queue_frame(48'hEEEE_0000_0001, 48'hDDDD_0000_0001, 3'd6, 32'd10);
		drain();
		// forward to a port that is not connected
		write_reg(mlft_pkg::REG_CONNECTED_PORTS, 32'h0F);
		queue_frame(48'hDDDD_0000_0001, 48'hEEEE_0000_0001, 3'd5, 32'd20);
		drain();
		// fill the table and overflow it
		write_reg(mlft_pkg::REG_AGE_LIMIT_MS, 32'hFFFF_FFFF);
		for (int i = 0; i < DEPTH + 4; i++)
			queue_frame(48'h1234_0000_0000 + i, 48'hEEEE_0000_0001, 3'(i % 8),
				32'd30 + i);
		drain();
		write_reg(mlft_pkg::REG_AGE_LIMIT_MS, 32'd0);
		queue_frame(48'h1234_0000_0000, 48'h1234_0000_0001, 3'd2, 32'd500);
		drain();

		// random phases with differing idling and settings
		write_reg(mlft_pkg::REG_AGE_LIMIT_MS, 32'd400);
		write_reg(mlft_pkg::REG_CONNECTED_PORTS, 32'hA5);
		random_phase(450, 0, 0, 32'd10000, 20);
		write_reg(mlft_pkg::REG_CONNECTED_PORTS, 32'h5A);
		write_reg(mlft_pkg::REG_AGE_LIMIT_MS, 32'd2000);
		random_phase(400, 79, 0, 32'hFFFF_0000, 30);
		write_reg(mlft_pkg::REG_CONNECTED_PORTS, 32'hFF);
		write_reg(mlft_pkg::REG_AGE_LIMIT_MS, 32'hFFFF_FFFF);
		random_phase(400, 0, 79, 32'd0, 50);
		write_reg(mlft_pkg::REG_CONNECTED_PORTS, 32'h00);
		write_reg(mlft_pkg::REG_AGE_LIMIT_MS, 32'd60);
		random_phase(400, 32, 32, 32'h8000_0000, 15);

		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
